@@ rtl/mtsel_pkg.sv @@
package mtsel_pkg;

    // object field widths
    localparam int MOMENTUM_BITS = 16;
    localparam int COUNT_BITS    = 8;
    localparam int ETA_BITS      = 14;
    localparam int FUNC_W        = 2;

    // register and result widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PT_CFG_W   = 16;
    localparam int ETA_CFG_W  = 14;
    localparam int REQ_W      = 8;
    localparam int MT_W       = 16;
    localparam int TOTAL_W    = 8;
    localparam int CAUSE_W    = 2;

    // transverse mass arithmetic widths
    localparam int SQ_W       = MOMENTUM_BITS + 1;
    localparam int PROD_W     = 2 * SQ_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int ROOT_W     = MOMENTUM_BITS + 1;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

    // item kinds
    localparam logic [FUNC_W-1:0] FUNC_MUON = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_JET  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MET  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_EOE  = 2'd3;

    // fail causes
    localparam logic [CAUSE_W-1:0] CAUSE_NONE = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_MUON = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_JET  = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_MT   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MUON_PT_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MUON_ETA_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JET_PT_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JET_ETA_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MUONS_REQ    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_JETS_REQ     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MT_EN        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MT_MIN       = 3'd7;

    // register reset values
    localparam logic [PT_CFG_W-1:0]  RST_MUON_PT_MIN  = 16'd160;
    localparam logic [ETA_CFG_W-1:0] RST_MUON_ETA_MAX = 14'd2150;
    localparam logic [PT_CFG_W-1:0]  RST_JET_PT_MIN   = 16'd240;
    localparam logic [ETA_CFG_W-1:0] RST_JET_ETA_MAX  = 14'd4915;
    localparam logic [REQ_W-1:0]     RST_MUONS_REQ    = 8'd1;
    localparam logic [REQ_W-1:0]     RST_JETS_REQ     = 8'd2;
    localparam logic                 RST_MT_EN        = 1'b0;
    localparam logic [MT_W-1:0]      RST_MT_MIN       = 16'd320;

    // squarer operand select
    typedef logic [2:0] t_op_sel;
    localparam t_op_sel OP_MUX = 3'd0;
    localparam t_op_sel OP_MUY = 3'd1;
    localparam t_op_sel OP_MX  = 3'd2;
    localparam t_op_sel OP_MY  = 3'd3;
    localparam t_op_sel OP_AB  = 3'd4;
    localparam t_op_sel OP_SX  = 3'd5;
    localparam t_op_sel OP_SY  = 3'd6;

    // accumulator operations
    typedef logic [1:0] t_acc_op;
    localparam t_acc_op ACC_HOLD = 2'd0;
    localparam t_acc_op ACC_LOAD = 2'd1;
    localparam t_acc_op ACC_ADD  = 2'd2;
    localparam t_acc_op ACC_SUB  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic    obj_update;
        t_op_sel op_sel;
        t_acc_op acc_op;
        logic    sqrt_start;
        logic    a_load;
        logic    b_load;
        logic    commit;
        logic    use_mt;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_fail;
        logic mt_en;
        logic sqrt_busy;
    } t_dp_stat;

endpackage

@@ rtl/mtsel_sqrt.sv @@
module mtsel_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mtsel_pkg::RAD_W-1:0] i_radicand,
    output logic                        o_busy,
    output logic [mtsel_pkg::ROOT_W-1:0] o_root
);
    import mtsel_pkg::*;

    logic                  r_busy, n_busy;
    logic [SQRT_CNT_W-1:0] r_cnt, n_cnt;
    logic [RAD_W-1:0]      r_rad, n_rad;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic [ROOT_W-1:0]     r_root, n_root;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;

    // one root bit per cycle, restoring digit recurrence
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = SQRT_CNT_W'(ROOT_W);
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = {r_rad[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - SQRT_CNT_W'(1);
            if (r_cnt == SQRT_CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

@@ rtl/mtsel_dp.sv @@
module mtsel_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mtsel_pkg::t_dp_cmd                     i_cmd,
    output mtsel_pkg::t_dp_stat                    o_stat,
    input  logic [mtsel_pkg::FUNC_W-1:0]           i_func,
    input  logic [mtsel_pkg::MOMENTUM_BITS-1:0]    i_trans_mom,
    input  logic signed [mtsel_pkg::ETA_BITS-1:0]  i_pseudorap,
    input  logic signed [mtsel_pkg::MOMENTUM_BITS-1:0] i_mom_x,
    input  logic signed [mtsel_pkg::MOMENTUM_BITS-1:0] i_mom_y,
    input  logic                                   i_cfg_we,
    input  logic [mtsel_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mtsel_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                   o_event_pass,
    output logic [mtsel_pkg::CAUSE_W-1:0]          o_fail_cause,
    output logic [mtsel_pkg::TOTAL_W-1:0]          o_muon_total,
    output logic [mtsel_pkg::TOTAL_W-1:0]          o_jet_total,
    output logic [mtsel_pkg::MT_W-1:0]             o_mt_value
);
    import mtsel_pkg::*;

    localparam int PT_X_W  = (MOMENTUM_BITS > PT_CFG_W) ? MOMENTUM_BITS : PT_CFG_W;
    localparam int CMP_W   = (COUNT_BITS > REQ_W) ? COUNT_BITS : REQ_W;
    localparam int TOT_X_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
    localparam int MTX_W   = (ROOT_W > MT_W) ? ROOT_W : MT_W;

    function automatic logic [SQ_W-1:0] mag_of(input logic [SQ_W-1:0] v);
        return v[SQ_W-1] ? (~v + SQ_W'(1)) : v;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [COUNT_BITS-1:0] c);
        logic [TOT_X_W-1:0] cx;
        cx = TOT_X_W'(c);
        return (cx > TOT_X_W'({TOTAL_W{1'b1}})) ? {TOTAL_W{1'b1}} : cx[TOTAL_W-1:0];
    endfunction

    // configuration registers
    logic [PT_CFG_W-1:0]  r_muon_pt_min;
    logic [ETA_CFG_W-1:0] r_muon_eta_max;
    logic [PT_CFG_W-1:0]  r_jet_pt_min;
    logic [ETA_CFG_W-1:0] r_jet_eta_max;
    logic [REQ_W-1:0]     r_muons_req;
    logic [REQ_W-1:0]     r_jets_req;
    logic                 r_mt_en;
    logic [MT_W-1:0]      r_mt_min;

    // event state
    logic [COUNT_BITS-1:0]           r_muon_tally;
    logic [COUNT_BITS-1:0]           r_jet_tally;
    logic                            r_met_seen;
    logic signed [MOMENTUM_BITS-1:0] r_mu_px, r_mu_py, r_met_px, r_met_py;

    // mass arithmetic
    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [ROOT_W-1:0] r_a, r_b;
    logic [SQ_W-1:0]   sq_op;
    logic [ROOT_W:0]   ab_full;
    logic signed [SQ_W-1:0] sx, sy;
    logic [RAD_W-1:0]  radicand;
    logic [ROOT_W-1:0] root;
    logic              sqrt_busy;

    logic [ETA_BITS-1:0] eta_raw, eta_mag;
    logic                muon_ok, jet_ok;
    logic                muon_fail, jet_fail;
    logic [MTX_W-1:0]    mt_x;
    logic                mt_low;
    logic [CAUSE_W-1:0]  cause;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_muon_pt_min  <= RST_MUON_PT_MIN;
            r_muon_eta_max <= RST_MUON_ETA_MAX;
            r_jet_pt_min   <= RST_JET_PT_MIN;
            r_jet_eta_max  <= RST_JET_ETA_MAX;
            r_muons_req    <= RST_MUONS_REQ;
            r_jets_req     <= RST_JETS_REQ;
            r_mt_en        <= RST_MT_EN;
            r_mt_min       <= RST_MT_MIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MUON_PT_MIN:  r_muon_pt_min  <= i_cfg_data[PT_CFG_W-1:0];
                CFG_MUON_ETA_MAX: r_muon_eta_max <= i_cfg_data[ETA_CFG_W-1:0];
                CFG_JET_PT_MIN:   r_jet_pt_min   <= i_cfg_data[PT_CFG_W-1:0];
                CFG_JET_ETA_MAX:  r_jet_eta_max  <= i_cfg_data[ETA_CFG_W-1:0];
                CFG_MUONS_REQ:    r_muons_req    <= i_cfg_data[REQ_W-1:0];
                CFG_JETS_REQ:     r_jets_req     <= i_cfg_data[REQ_W-1:0];
                CFG_MT_EN:        r_mt_en        <= i_cfg_data[0];
                CFG_MT_MIN:       r_mt_min       <= i_cfg_data[MT_W-1:0];
                default: ;
            endcase
        end
    end

    // object cuts
    assign eta_raw = i_pseudorap;
    assign eta_mag = eta_raw[ETA_BITS-1] ? (~eta_raw + ETA_BITS'(1)) : eta_raw;
    assign muon_ok = (PT_X_W'(i_trans_mom) > PT_X_W'(r_muon_pt_min))
                     && (eta_mag < r_muon_eta_max);
    assign jet_ok  = (PT_X_W'(i_trans_mom) > PT_X_W'(r_jet_pt_min))
                     && (eta_mag < r_jet_eta_max);

    // event state: counts, kept vectors, cleared when a result is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.commit) begin
            r_muon_tally <= '0;
            r_jet_tally  <= '0;
            r_met_seen   <= 1'b0;
            r_mu_px      <= '0;
            r_mu_py      <= '0;
            r_met_px     <= '0;
            r_met_py     <= '0;
        end else if (i_cmd.obj_update) begin
            case (i_func)
                FUNC_MUON: begin
                    if (muon_ok) begin
                        r_mu_px <= i_mom_x;
                        r_mu_py <= i_mom_y;
                        if (r_muon_tally != {COUNT_BITS{1'b1}}) begin
                            r_muon_tally <= r_muon_tally + COUNT_BITS'(1);
                        end
                    end
                end
                FUNC_JET: begin
                    if (jet_ok && r_jet_tally != {COUNT_BITS{1'b1}}) begin
                        r_jet_tally <= r_jet_tally + COUNT_BITS'(1);
                    end
                end
                FUNC_MET: begin
                    if (!r_met_seen) begin
                        r_met_px   <= i_mom_x;
                        r_met_py   <= i_mom_y;
                        r_met_seen <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // squarer operand select
    assign sx      = SQ_W'(r_mu_px) + SQ_W'(r_met_px);
    assign sy      = SQ_W'(r_mu_py) + SQ_W'(r_met_py);
    assign ab_full = (ROOT_W+1)'(r_a) + (ROOT_W+1)'(r_b);

    always_comb begin
        case (i_cmd.op_sel)
            OP_MUX:  sq_op = mag_of(SQ_W'(r_mu_px));
            OP_MUY:  sq_op = mag_of(SQ_W'(r_mu_py));
            OP_MX:   sq_op = mag_of(SQ_W'(r_met_px));
            OP_MY:   sq_op = mag_of(SQ_W'(r_met_py));
            OP_AB:   sq_op = ab_full[SQ_W-1:0];
            OP_SX:   sq_op = mag_of(sx);
            OP_SY:   sq_op = mag_of(sy);
            default: sq_op = '0;
        endcase
    end

    // registered square, then accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(sq_op) * PROD_W'(sq_op);
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= ACC_W'(r_prod);
            ACC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
            ACC_SUB:  r_acc <= r_acc - ACC_W'(r_prod);
            default:  r_acc <= r_acc;
        endcase
        if (i_cmd.a_load) begin
            r_a <= root;
        end
        if (i_cmd.b_load) begin
            r_b <= root;
        end
    end

    // negative mass squared clamps to zero
    assign radicand = r_acc[ACC_W-1] ? '0 : r_acc[RAD_W-1:0];

    mtsel_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (radicand),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    // end of event checks
    assign muon_fail = CMP_W'(r_muon_tally) != CMP_W'(r_muons_req);
    assign jet_fail  = CMP_W'(r_jet_tally) != CMP_W'(r_jets_req);
    assign mt_x      = MTX_W'(root);
    assign mt_low    = mt_x < MTX_W'(r_mt_min);

    always_comb begin
        if (muon_fail) begin
            cause = CAUSE_MUON;
        end else if (jet_fail) begin
            cause = CAUSE_JET;
        end else if (i_cmd.use_mt && mt_low) begin
            cause = CAUSE_MT;
        end else begin
            cause = CAUSE_NONE;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            o_event_pass <= (cause == CAUSE_NONE);
            o_fail_cause <= cause;
            o_muon_total <= sat_total(r_muon_tally);
            o_jet_total  <= sat_total(r_jet_tally);
            if (i_cmd.use_mt) begin
                o_mt_value <= (mt_x > MTX_W'({MT_W{1'b1}})) ? {MT_W{1'b1}}
                                                             : mt_x[MT_W-1:0];
            end else begin
                o_mt_value <= '0;
            end
        end
    end

    assign o_stat.count_fail = muon_fail || jet_fail;
    assign o_stat.mt_en      = r_mt_en;
    assign o_stat.sqrt_busy  = sqrt_busy;

endmodule

@@ rtl/mtsel_ctrl.sv @@
module mtsel_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [mtsel_pkg::FUNC_W-1:0] i_func,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output mtsel_pkg::t_dp_cmd           o_cmd,
    input  mtsel_pkg::t_dp_stat          i_stat
);
    import mtsel_pkg::*;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_CHK  = 5'd1;
    localparam logic [4:0] ST_M0   = 5'd2;
    localparam logic [4:0] ST_M1   = 5'd3;
    localparam logic [4:0] ST_M2   = 5'd4;
    localparam logic [4:0] ST_RA0  = 5'd5;
    localparam logic [4:0] ST_RAW  = 5'd6;
    localparam logic [4:0] ST_M3   = 5'd7;
    localparam logic [4:0] ST_M4   = 5'd8;
    localparam logic [4:0] ST_M5   = 5'd9;
    localparam logic [4:0] ST_RB0  = 5'd10;
    localparam logic [4:0] ST_RBW  = 5'd11;
    localparam logic [4:0] ST_M6   = 5'd12;
    localparam logic [4:0] ST_M7   = 5'd13;
    localparam logic [4:0] ST_M8   = 5'd14;
    localparam logic [4:0] ST_M9   = 5'd15;
    localparam logic [4:0] ST_RM0  = 5'd16;
    localparam logic [4:0] ST_RMW  = 5'd17;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       in_acc;
    logic       out_free;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // sequencer: checks, then two norms, the squared norm sum less the squared vector sums, and the mass root
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_func == FUNC_EOE) begin
                        n_state = ST_CHK;
                    end else begin
                        o_cmd.obj_update = 1'b1;
                    end
                end
            end
            ST_CHK: begin
                if (i_stat.count_fail || !i_stat.mt_en) begin
                    if (out_free) begin
                        o_cmd.commit = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_state = ST_M0;
                end
            end
            ST_M0: begin
                o_cmd.op_sel = OP_MUX;
                n_state      = ST_M1;
            end
            ST_M1: begin
                o_cmd.op_sel = OP_MUY;
                o_cmd.acc_op = ACC_LOAD;
                n_state      = ST_M2;
            end
            ST_M2: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = ST_RA0;
            end
            ST_RA0: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = ST_RAW;
            end
            ST_RAW: begin
                if (!i_stat.sqrt_busy) begin
                    o_cmd.a_load = 1'b1;
                    n_state      = ST_M3;
                end
            end
            ST_M3: begin
                o_cmd.op_sel = OP_MX;
                n_state      = ST_M4;
            end
            ST_M4: begin
                o_cmd.op_sel = OP_MY;
                o_cmd.acc_op = ACC_LOAD;
                n_state      = ST_M5;
            end
            ST_M5: begin
                o_cmd.acc_op = ACC_ADD;
                n_state      = ST_RB0;
            end
            ST_RB0: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = ST_RBW;
            end
            ST_RBW: begin
                if (!i_stat.sqrt_busy) begin
                    o_cmd.b_load = 1'b1;
                    n_state      = ST_M6;
                end
            end
            ST_M6: begin
                o_cmd.op_sel = OP_AB;
                n_state      = ST_M7;
            end
            ST_M7: begin
                o_cmd.op_sel = OP_SX;
                o_cmd.acc_op = ACC_LOAD;
                n_state      = ST_M8;
            end
            ST_M8: begin
                o_cmd.op_sel = OP_SY;
                o_cmd.acc_op = ACC_SUB;
                n_state      = ST_M9;
            end
            ST_M9: begin
                o_cmd.acc_op = ACC_SUB;
                n_state      = ST_RM0;
            end
            ST_RM0: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = ST_RMW;
            end
            ST_RMW: begin
                o_cmd.use_mt = 1'b1;
                if (!i_stat.sqrt_busy && out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/event_muon_jet_mt_selector_top.sv @@
// object words (muon, jet, missing energy): one per cycle while idle, no result
// end-of-event word with a count failure or the mass check off: result from ST_CHK
// end-of-event word with the mass check: result after three passes of the
// one-bit-per-cycle root unit and the shared squarer
// a waiting result does not block object words; the next end-of-event waits for it
// synchronous active-low reset loads register defaults and clears event state
module event_muon_jet_mt_selector_top (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  logic [mtsel_pkg::FUNC_W-1:0]               i_func,
    input  logic [mtsel_pkg::MOMENTUM_BITS-1:0]        i_trans_mom,
    input  logic signed [mtsel_pkg::ETA_BITS-1:0]      i_pseudorap,
    input  logic signed [mtsel_pkg::MOMENTUM_BITS-1:0] i_mom_x,
    input  logic signed [mtsel_pkg::MOMENTUM_BITS-1:0] i_mom_y,
    output logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    output logic                                       o_event_pass,
    output logic [mtsel_pkg::CAUSE_W-1:0]              o_fail_cause,
    output logic [mtsel_pkg::TOTAL_W-1:0]              o_muon_total,
    output logic [mtsel_pkg::TOTAL_W-1:0]              o_jet_total,
    output logic [mtsel_pkg::MT_W-1:0]                 o_mt_value,
    input  logic                                       i_cfg_we,
    input  logic [mtsel_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [mtsel_pkg::CFG_DATA_W-1:0]           i_cfg_data
);
    import mtsel_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    mtsel_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // cuts, counts, mass arithmetic and result word
    mtsel_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (i_func),
        .i_trans_mom  (i_trans_mom),
        .i_pseudorap  (i_pseudorap),
        .i_mom_x      (i_mom_x),
        .i_mom_y      (i_mom_y),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_event_pass (o_event_pass),
        .o_fail_cause (o_fail_cause),
        .o_muon_total (o_muon_total),
        .o_jet_total  (o_jet_total),
        .o_mt_value   (o_mt_value)
    );

endmodule

@@ rtl/mtsel_checker.sv @@
module mtsel_checker (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    input  logic                                       o_in_stall,
    input  logic [mtsel_pkg::FUNC_W-1:0]               i_func,
    input  logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    input  logic                                       o_event_pass,
    input  logic [mtsel_pkg::CAUSE_W-1:0]              o_fail_cause,
    input  logic [mtsel_pkg::TOTAL_W-1:0]              o_muon_total,
    input  logic [mtsel_pkg::TOTAL_W-1:0]              o_jet_total,
    input  logic [mtsel_pkg::MT_W-1:0]                 o_mt_value
);
    import mtsel_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_fail_cause)
            && $stable(o_mt_value) && $stable(o_muon_total) && $stable(o_jet_total)))
        else $error("result word changed while stalled");

    // an object word never produces a result
    a_obj_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_func != FUNC_EOE && !o_out_valid)
            |=> !o_out_valid)
        else $error("result after an object word");

    // end of event stops input while the result is formed
    a_eoe_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_func == FUNC_EOE) |=> o_in_stall)
        else $error("input taken right after end of event");

    // pass flag agrees with the cause
    a_pass_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_pass == (o_fail_cause == CAUSE_NONE)))
        else $error("pass flag and fail cause disagree");

    // a count failure reports no mass
    a_count_fail_mt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_fail_cause == CAUSE_MUON || o_fail_cause == CAUSE_JET))
            |-> (o_mt_value == '0))
        else $error("mass reported on a count failure");

endmodule

bind event_muon_jet_mt_selector_top mtsel_checker u_checker (.*);
